// ===== hw/rtl/rational_arithmetic_unit_assert.svh =====
// Assertion macros used by the rational arithmetic unit top level.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define RAU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked at every clock edge out of reset.
`define RAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rau_pkg.sv =====
// Types, codes and constants of the rational arithmetic unit.
package rau_pkg;

  localparam int RAU_OPW    = 32;  // default operand width
  localparam int RAU_PW     = 64;  // product / gcd datapath width
  localparam int RAU_QDEPTH = 2;   // front-to-back queue depth

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CMP  = 3'd4;
  localparam logic [2:0] OP_NORM = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               greater;
    logic               equal;
    logic [1:0]         status;
  } rau_out_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic              direct;   // result is final, no reduction needed
    logic [1:0]        status;
    logic              greater;
    logic              equal;
    logic              neg;
    logic [RAU_PW-1:0] nm;
    logic [RAU_PW-1:0] dm;
  } rau_job_t;

  typedef enum logic [1:0] {
    FR_IDLE, FR_MUL, FR_COMB, FR_PUSH
  } rau_fr_state_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_TWO, BK_GCD, BK_DIV, BK_CHECK, BK_DONE
  } rau_bk_state_t;

endpackage

// ===== hw/rtl/rau_front.sv =====
// Front end: accepts a beat, forms cross products, classifies the job.
module rau_front #(
  parameter int OPERAND_WIDTH = rau_pkg::RAU_OPW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rau_pkg::rau_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output rau_pkg::rau_job_t job
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int W2 = 2 * OPERAND_WIDTH;

  rau_fr_state_t state_r, state_nxt;
  logic [2:0]    op_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic          sa_r, sb_r;
  logic [1:0]    mcnt_r;
  logic [W2-1:0] p0_r, p1_r, p2_r;
  rau_job_t      job_r, job_nxt;

  logic [W-1:0]  an_v, ad_v, bn_v, bd_v;
  logic [W-1:0]  an_m, ad_m, bn_m, bd_m;
  logic [W-1:0]  mx, my, one_w;
  logic [W2-1:0] prod;
  logic          accept;

  // operand magnitudes, sign taken from bit W-1
  always_comb begin
    an_v = in_data.a_num[W-1:0];
    ad_v = in_data.a_den[W-1:0];
    bn_v = in_data.b_num[W-1:0];
    bd_v = in_data.b_den[W-1:0];
    an_m = an_v[W-1] ? (~an_v + 1'b1) : an_v;
    ad_m = ad_v[W-1] ? (~ad_v + 1'b1) : ad_v;
    bn_m = bn_v[W-1] ? (~bn_v + 1'b1) : bn_v;
    bd_m = bd_v[W-1] ? (~bd_v + 1'b1) : bd_v;
  end

  // shared multiplier, one product per cycle
  assign one_w = W'(1);
  always_comb begin
    case (mcnt_r)
      2'd0: begin
        mx = an_r;
        my = (op_r == OP_MUL) ? bn_r : ((op_r == OP_NORM) ? one_w : bd_r);
      end
      2'd1: begin
        mx = ad_r;
        my = (op_r == OP_DIV) ? bn_r : ((op_r == OP_NORM) ? one_w : bd_r);
      end
      default: begin
        mx = bn_r;
        my = ad_r;
      end
    endcase
  end
  assign prod = W2'(mx) * W2'(my);

  // classification and sum / compare
  logic          sq, same, pge;
  logic [W2-1:0] sum;
  logic          sneg;
  logic [W2:0]   lval, rval;
  always_comb begin
    sq   = (op_r == OP_SUB) ? !sb_r : sb_r;
    same = (sa_r == sq);
    pge  = (p0_r >= p2_r);
    if (same) begin
      sum  = p0_r + p2_r;
      sneg = sa_r;
    end else if (pge) begin
      sum  = p0_r - p2_r;
      sneg = sa_r;
    end else begin
      sum  = p2_r - p0_r;
      sneg = sq;
    end
    lval = sa_r ? (~{1'b0, p0_r} + 1'b1) : {1'b0, p0_r};
    rval = sb_r ? (~{1'b0, p2_r} + 1'b1) : {1'b0, p2_r};

    job_nxt         = '0;
    job_nxt.dm      = RAU_PW'(p1_r);
    job_nxt.status  = ST_OK;
    if (op_r > OP_NORM) begin
      job_nxt.direct = 1'b1;
    end else if (ad_r == '0 || (op_r != OP_NORM && bd_r == '0)) begin
      job_nxt.direct = 1'b1;
      job_nxt.status = ST_ZDEN;
      job_nxt.dm     = '0;
    end else if (op_r == OP_DIV && bn_r == '0) begin
      job_nxt.direct = 1'b1;
      job_nxt.status = ST_DIVZ;
      job_nxt.dm     = '0;
    end else if (op_r == OP_CMP) begin
      job_nxt.direct  = 1'b1;
      job_nxt.dm      = '0;
      job_nxt.greater = ($signed(lval) > $signed(rval));
      job_nxt.equal   = (lval == rval);
    end else if (op_r == OP_ADD || op_r == OP_SUB) begin
      job_nxt.nm  = RAU_PW'(sum);
      job_nxt.neg = sneg;
    end else begin
      job_nxt.nm  = RAU_PW'(p0_r);
      job_nxt.neg = (op_r == OP_NORM) ? sa_r : (sa_r ^ sb_r);
    end
  end

  // control
  always_comb begin
    state_nxt = state_r;
    in_full   = 1'b1;
    job_valid = 1'b0;
    unique case (state_r)
      FR_IDLE: begin
        in_full = 1'b0;
        if (in_push) state_nxt = FR_MUL;
      end
      FR_MUL:  if (mcnt_r == 2'd2) state_nxt = FR_COMB;
      FR_COMB: state_nxt = FR_PUSH;
      FR_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) state_nxt = FR_IDLE;
      end
      default: state_nxt = FR_IDLE;
    endcase
  end
  assign accept = in_push && !in_full;
  assign job    = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      mcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) mcnt_r <= '0;
      else if (state_r == FR_MUL) mcnt_r <= mcnt_r + 2'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_data.opcode;
      an_r <= an_m;
      ad_r <= ad_m;
      bn_r <= bn_m;
      bd_r <= bd_m;
      sa_r <= an_v[W-1] ^ ad_v[W-1];
      sb_r <= bn_v[W-1] ^ bd_v[W-1];
    end
    if (state_r == FR_MUL) begin
      case (mcnt_r)
        2'd0:    p0_r <= prod;
        2'd1:    p1_r <= prod;
        default: p2_r <= prod;
      endcase
    end
    if (state_r == FR_COMB) job_r <= job_nxt;
  end

endmodule

// ===== hw/rtl/rau_queue.sv =====
// Short job queue between front and back ends.
module rau_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  rau_pkg::rau_job_t wdata,
  input  logic              pop,
  output logic              empty,
  output rau_pkg::rau_job_t rdata
);
  import rau_pkg::*;

  localparam int PtrW = (RAU_QDEPTH > 1) ? $clog2(RAU_QDEPTH) : 1;
  localparam int CntW = $clog2(RAU_QDEPTH + 1);

  rau_job_t        mem_r [RAU_QDEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(RAU_QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(RAU_QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(RAU_QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== hw/rtl/rau_back.sv =====
// Back end: binary gcd, exact division by the gcd, range check, result register.
module rau_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  rau_pkg::rau_job_t job,
  output logic              out_empty,
  input  logic              out_pop,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  localparam int PW   = RAU_PW;
  localparam int CntW = $clog2(RAU_PW);

  rau_bk_state_t   state_r, state_nxt;
  logic [PW-1:0]   x_r, y_r, g_r;
  logic [PW-1:0]   nm_r, dm_r, nq_r, dq_r, nrem_r, drem_r;
  logic [CntW-1:0] k_r, cnt_r;
  logic            neg_r;
  rau_out_t        res_r, out_r;
  logic            ovalid_r;

  logic          load_out;
  logic [PW:0]   nt, dt;
  logic          nbit, dbit;
  logic          neg2, ovf;
  logic [PW-1:0] min_mag;

  // one restoring division step for numerator and denominator
  always_comb begin
    nt   = {nrem_r, nq_r[PW-1]};
    dt   = {drem_r, dq_r[PW-1]};
    nbit = (nt >= {1'b0, g_r});
    dbit = (dt >= {1'b0, g_r});
  end

  // range check of the reduced fraction
  assign min_mag = {1'b1, {(PW-1){1'b0}}};
  assign neg2    = neg_r && (nq_r != '0);
  assign ovf     = dq_r[PW-1] || (!neg2 && nq_r[PW-1]) || (neg2 && nq_r > min_mag);

  // control
  always_comb begin
    state_nxt = state_r;
    job_ready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) state_nxt = job.direct ? BK_DONE : BK_TWO;
      end
      BK_TWO: begin
        if (x_r == '0 || x_r[0] || y_r[0]) state_nxt = BK_GCD;
      end
      BK_GCD:   if (x_r == '0) state_nxt = BK_DIV;
      BK_DIV:   if (cnt_r == CntW'(PW - 1)) state_nxt = BK_CHECK;
      BK_CHECK: state_nxt = BK_DONE;
      BK_DONE: begin
        if (!ovalid_r || out_pop) begin
          load_out  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) ovalid_r <= 1'b1;
      else if (out_pop) ovalid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          x_r   <= job.nm;
          y_r   <= job.dm;
          nm_r  <= job.nm;
          dm_r  <= job.dm;
          neg_r <= job.neg;
          k_r   <= '0;
          res_r <= '{res_num: '0, res_den: '0, greater: job.greater,
                     equal: job.equal, status: job.status};
        end
      end
      BK_TWO: begin
        // strip common factors of two
        if (x_r != '0 && !x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end
      end
      BK_GCD: begin
        if (x_r == '0) begin
          g_r    <= y_r << k_r;
          cnt_r  <= '0;
          nq_r   <= nm_r;
          dq_r   <= dm_r;
          nrem_r <= '0;
          drem_r <= '0;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= (x_r - y_r) >> 1;
        end else begin
          y_r <= (y_r - x_r) >> 1;
        end
      end
      BK_DIV: begin
        nrem_r <= nbit ? PW'(nt - {1'b0, g_r}) : PW'(nt);
        drem_r <= dbit ? PW'(dt - {1'b0, g_r}) : PW'(dt);
        nq_r   <= {nq_r[PW-2:0], nbit};
        dq_r   <= {dq_r[PW-2:0], dbit};
        cnt_r  <= cnt_r + 1'b1;
      end
      BK_CHECK: begin
        if (ovf) begin
          res_r.status <= ST_OVF;
        end else begin
          res_r.res_num <= neg2 ? $signed(~nq_r + 1'b1) : $signed(nq_r);
          res_r.res_den <= dq_r[62:0];
        end
      end
      default: ;
    endcase
    if (load_out) out_r <= res_r;
  end

  assign out_empty = !ovalid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Flow: the front accepts a beat, forms the cross products in FR_MUL, combines them in
// FR_COMB and pushes the job to the queue; the back end loads it, strips common twos,
// runs the binary gcd, 64 division steps and the range check, then loads the output.
// Compare, error and unused-opcode beats skip the gcd and the division. The front takes
// a new beat only once its last job is in the queue. Output stalls hold the back end.
// Reset: synchronous active-low rst_n empties the queue and result register.
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::RAU_OPW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  rau_job_t f_job, q_job;
  logic     f_valid, f_ready, q_full, q_empty, b_ready;

  assign f_ready = !q_full;

  // classify and form products
  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  rau_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .full  (q_full),
    .wdata (f_job),
    .pop   (b_ready),
    .empty (q_empty),
    .rdata (q_job)
  );

  // reduce and deliver
  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job_ready (b_ready),
    .job       (q_job),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  `RAU_ASSERT_IMPL(a_err_zero, !out_empty && out_data.status != ST_OK,
    out_data.res_num == '0 && out_data.res_den == '0, "error result not zeroed")
  `RAU_ASSERT_IMPL(a_cmp_excl, !out_empty && out_data.greater,
    !out_data.equal, "greater and equal both set")
  `RAU_ASSERT_IMPL(a_den_zero, !out_empty && out_data.res_den == '0,
    out_data.res_num == '0, "zero denominator with nonzero numerator")

endmodule

// ===== tb/sv/rational_arithmetic_unit_tb.sv =====
// Self-checking testbench for the rational arithmetic unit: directed and random fractions.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_push;
  logic     in_full;
  rau_in_t  in_data;
  logic     out_empty;
  logic     out_pop;
  rau_out_t out_data;

  rau_out_t expected_fracs[$];
  int       n_errors;
  int       n_sent;
  int       n_checked;
  int       op_hits[8];
  int       status_hits[4];

  rational_arithmetic_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // magnitude and sign of a 32-bit operand
  function automatic logic [63:0] operand_mag(logic [31:0] raw, output logic neg);
    neg = raw[31];
    return raw[31] ? {32'd0, (~raw) + 32'd1} | (raw == 32'h8000_0000 ? 64'h8000_0000 : 64'd0)
                   : {32'd0, raw};
  endfunction

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (x != 64'd0) begin
      t = y % x;
      y = x;
      x = t;
    end
    return y;
  endfunction

  // reduce (neg, nm) / dm into a result beat
  function automatic rau_out_t reduced_frac(logic neg, logic [63:0] nm, logic [63:0] dm);
    rau_out_t r;
    logic [63:0] g;
    r = '0;
    g = euclid_gcd(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (nm == 64'd0) neg = 1'b0;
    if (dm[63] || (!neg && nm[63]) || (neg && nm > 64'h8000_0000_0000_0000)) begin
      r.status = ST_OVF;
      return r;
    end
    r.res_num = neg ? (~nm) + 64'd1 : nm;
    r.res_den = dm[62:0];
    r.status  = ST_OK;
    return r;
  endfunction

  function automatic rau_out_t predict_frac(rau_in_t x);
    rau_out_t r;
    logic an, ad, bn, bd, sa, sb, sq, neg;
    logic [63:0] anm, adm, bnm, bdm, p, q, nm;
    logic signed [63:0] lhs, rhs;
    r = '0;
    anm = operand_mag(x.a_num, an);
    adm = operand_mag(x.a_den, ad);
    bnm = operand_mag(x.b_num, bn);
    bdm = operand_mag(x.b_den, bd);
    sa = an ^ ad;
    sb = bn ^ bd;
    if (x.opcode > OP_NORM) return r;
    if (adm == 64'd0 || (x.opcode != OP_NORM && bdm == 64'd0)) begin
      r.status = ST_ZDEN;
      return r;
    end
    case (x.opcode)
      OP_ADD, OP_SUB: begin
        p  = anm * bdm;
        q  = bnm * adm;
        sq = (x.opcode == OP_SUB) ? !sb : sb;
        if (sa == sq) begin
          nm = p + q; neg = sa;
        end else if (p >= q) begin
          nm = p - q; neg = sa;
        end else begin
          nm = q - p; neg = sq;
        end
        r = reduced_frac(neg, nm, adm * bdm);
      end
      OP_MUL: r = reduced_frac(sa ^ sb, anm * bnm, adm * bdm);
      OP_DIV: begin
        if (bnm == 64'd0) r.status = ST_DIVZ;
        else r = reduced_frac(sa ^ sb, anm * bdm, adm * bnm);
      end
      OP_CMP: begin
        lhs = sa ? -$signed(anm * bdm) : $signed(anm * bdm);
        rhs = sb ? -$signed(bnm * adm) : $signed(bnm * adm);
        r.greater = lhs > rhs;
        r.equal   = lhs == rhs;
      end
      default: r = reduced_frac(sa, anm, adm);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp);
    n_errors++;
    $display("%0t MISMATCH beat %0d %s: got %h expected %h",
             $realtime, n_checked, field, got, exp);
  endtask

  // send one beat with a random lead-in gap; push stays high across gap-free beats
  task automatic send_frac(rau_in_t x);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_full);
    expected_fracs.push_back(predict_frac(x));
    op_hits[x.opcode]++;
    n_sent++;
  endtask

  function automatic rau_in_t mk(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                                 logic [31:0] bn, logic [31:0] bd);
    rau_in_t x;
    x.opcode = op; x.a_num = an; x.a_den = ad; x.b_num = bn; x.b_den = bd;
    return x;
  endfunction

  // result side: check every accepted beat, with random stalls between pops
  initial begin
    int stall;
    rau_out_t e;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (expected_fracs.size() == 0) begin
          report_mismatch("unexpected beat", out_data.res_num, 64'd0);
        end else begin
          e = expected_fracs.pop_front();
          if (out_data.res_num !== e.res_num)
            report_mismatch("res_num", out_data.res_num, e.res_num);
          if (out_data.res_den !== e.res_den)
            report_mismatch("res_den", 64'(out_data.res_den), 64'(e.res_den));
          if (out_data.greater !== e.greater)
            report_mismatch("greater", 64'(out_data.greater), 64'(e.greater));
          if (out_data.equal !== e.equal)
            report_mismatch("equal", 64'(out_data.equal), 64'(e.equal));
          if (out_data.status !== e.status)
            report_mismatch("status", 64'(out_data.status), 64'(e.status));
          status_hits[e.status]++;
        end
        n_checked++;
        stall = $urandom_range(0, 3);
        out_pop <= (stall == 0);
      end else if (stall > 0) begin
        stall--;
        out_pop <= (stall == 0);
      end
    end
  end

  task automatic test_reset();
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    rst_n   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n   <= 1'b1;
    out_pop <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_each_opcode();
    send_frac(mk(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
    send_frac(mk(OP_SUB, 32'd1, 32'd2, 32'd3, 32'd4));
    send_frac(mk(OP_MUL, -32'sd6, 32'd4, 32'd2, -32'sd9));
    send_frac(mk(OP_DIV, 32'd3, -32'sd5, -32'sd6, 32'd7));
    send_frac(mk(OP_CMP, 32'd2, 32'd4, 32'd1, 32'd2));
    send_frac(mk(OP_CMP, -32'sd1, 32'd3, 32'd1, -32'sd4));
    send_frac(mk(OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2));
    send_frac(mk(OP_NORM, 32'd12, -32'sd18, 32'd0, 32'd0));
    send_frac(mk(OP_ADD, 32'd0, -32'sd7, 32'd0, 32'd5));
  endtask

  task automatic test_error_cases();
    // zero denominator on a, on b, and b ignored by normalize
    send_frac(mk(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1));
    send_frac(mk(OP_MUL, 32'd1, 32'd1, 32'd1, 32'd0));
    send_frac(mk(OP_NORM, 32'd4, 32'd2, 32'd1, 32'd0));
    // division by a zero fraction
    send_frac(mk(OP_DIV, 32'd5, 32'd3, 32'd0, -32'sd2));
    // unused opcodes
    send_frac(mk(3'd6, 32'd1, 32'd2, 32'd3, 32'd4));
    send_frac(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // large sum: 2^31 - (-2^31) over 1 gives 2^32 exactly
    send_frac(mk(OP_SUB, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1));
  endtask

  task automatic test_extremes();
    send_frac(mk(OP_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1));
    send_frac(mk(OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_frac(mk(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_frac(mk(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_frac(mk(OP_NORM, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0));
    send_frac(mk(OP_SUB, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFD));
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2, 3: return $urandom_range(0, 40) - 20;
      4:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      5, 6:    return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_fracs(int count);
    rau_in_t x;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 31) == 0) x.opcode = 3'($urandom_range(6, 7));
      else x.opcode = 3'($urandom_range(0, 5));
      x.a_num  = rand_operand();
      x.a_den  = rand_operand();
      x.b_num  = rand_operand();
      x.b_den  = rand_operand();
      // keep most denominators nonzero so the arithmetic paths dominate
      if (x.a_den == 0 && $urandom_range(0, 3) != 0) x.a_den = 32'd1;
      if (x.b_den == 0 && $urandom_range(0, 3) != 0) x.b_den = -32'sd1;
      send_frac(x);
    end
  endtask

  // main sequence
  initial begin
    n_errors = 0; n_sent = 0; n_checked = 0;
    test_reset();
    test_each_opcode();
    test_error_cases();
    test_extremes();
    test_random_fracs(950);
    in_push <= 1'b0;
    while (expected_fracs.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d beats: add %0d sub %0d mul %0d div %0d cmp %0d norm %0d unused %0d",
             n_sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4], op_hits[5],
             op_hits[6] + op_hits[7]);
    $display("Statuses ok %0d zero-den %0d div-zero %0d overflow %0d; %0d mismatches",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("Timeout with %0d beats outstanding", expected_fracs.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
